[hdl/rdz_pkg.sv]
// Shared types and constants for the stick radial deadzone pipeline.
// No dependencies; imported by every module of the block.
package rdz_pkg;

	// Sample and output formats
	localparam int SAMPLE_BITS = 12;
	localparam int FULL_SCALE  = 32767;
	localparam int OUT_W       = 16;
	localparam int RAD_W       = 12;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = RAD_W;
	localparam int RAD_SQ_W   = 2 * RAD_W;
	localparam int OUTER_RESET = 4095;
	localparam logic [RAD_SQ_W-1:0] OUTER_SQ_RESET = RAD_SQ_W'(OUTER_RESET * OUTER_RESET);

	// Centring and magnitude widths
	localparam int HALF  = 1 << (SAMPLE_BITS - 1);
	localparam int CEN_W = SAMPLE_BITS + 1;
	localparam int MAG_W = SAMPLE_BITS;
	localparam int SQ_W  = 2 * MAG_W;
	// cx^2 + cy^2 never exceeds 2^(2*SAMPLE_BITS-1), so it fits SQ_W bits
	localparam int M2_W  = SQ_W;

	// Projection arithmetic: quotient of FS^2*mag^2 / m2 is at most FS^2
	localparam int FS_W   = $clog2(FULL_SCALE + 1);
	localparam int FS2_W  = 2 * FS_W;
	localparam logic [FS2_W-1:0] FS_SQ = FS2_W'(FULL_SCALE * FULL_SCALE);
	localparam int Q_W    = FS2_W;
	localparam int NUM_W  = FS2_W + SQ_W;
	localparam int ROOT_W = FS_W;
	localparam int SR_W   = ROOT_W + 1;

	// Output buffer
	localparam int OBUF_DEPTH = 2;
	localparam int PTR_W      = $clog2(OBUF_DEPTH);
	localparam int CNT_W      = $clog2(OBUF_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INNER = CFG_IDX_W'(0),
		REG_OUTER = CFG_IDX_W'(1)
	} cfg_reg_t;

	// Sideband that travels with each sample through the root and divide
	typedef struct packed {
		logic             proj;
		logic             neg_x;
		logic             neg_y;
		logic [OUT_W-1:0] pass_x;
		logic [OUT_W-1:0] pass_y;
	} side_t;

endpackage

[hdl/rdz_front.sv]
// Front end: centring, squares, radius compares and projection numerators.
// Holds the two radius registers. Depends on rdz_pkg.
module rdz_front import rdz_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [SAMPLE_BITS-1:0] raw_x,
	input  logic [SAMPLE_BITS-1:0] raw_y,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                  v_s3,
	output logic [M2_W-1:0]       m2_s3,
	output logic [NUM_W-1:0]      num_x_s3,
	output logic [NUM_W-1:0]      num_y_s3,
	output side_t                 side_s3
);

	logic [RAD_SQ_W-1:0] inner_sq_q;
	logic [RAD_SQ_W-1:0] outer_sq_q;

	// Keep squared radii so the datapath compares squares directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_sq_q <= '0;
			outer_sq_q <= OUTER_SQ_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_INNER: inner_sq_q <= RAD_SQ_W'(cfg_wdata * cfg_wdata);
				REG_OUTER: outer_sq_q <= RAD_SQ_W'(cfg_wdata * cfg_wdata);
				default: ;
			endcase
		end
	end

	// Stage 1: centre, flip y, take magnitudes
	logic signed [CEN_W-1:0] cx_c, cy_c;
	logic [MAG_W-1:0]        magx_c, magy_c;

	assign cx_c   = $signed({1'b0, raw_x}) - $signed(CEN_W'(HALF));
	assign cy_c   = $signed(CEN_W'(HALF)) - $signed({1'b0, raw_y});
	assign magx_c = cx_c[CEN_W-1] ? MAG_W'(-cx_c) : MAG_W'(cx_c);
	assign magy_c = cy_c[CEN_W-1] ? MAG_W'(-cy_c) : MAG_W'(cy_c);

	logic                    v_s1, v_s2;
	logic signed [CEN_W-1:0] cx_s1, cy_s1, cx_s2, cy_s2;
	logic [MAG_W-1:0]        magx_s1, magy_s1;
	logic [SQ_W-1:0]         sqx_s2, sqy_s2;

	// Advance valid bits with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 3 combinational: sum of squares, compares, projection numerators
	logic [M2_W:0]      sum_c;
	logic [M2_W-1:0]    m2_c;
	logic               below_c, above_c;
	logic [NUM_W-1:0]   numx_c, numy_c;

	assign sum_c   = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign m2_c    = sum_c[M2_W-1:0];
	assign below_c = ({{(RAD_SQ_W > M2_W ? RAD_SQ_W - M2_W : 0){1'b0}}, m2_c} < inner_sq_q);
	assign above_c = ({{(RAD_SQ_W > M2_W ? RAD_SQ_W - M2_W : 0){1'b0}}, m2_c} > outer_sq_q);
	assign numx_c  = FS_SQ * sqx_s2;
	assign numy_c  = FS_SQ * sqy_s2;

	// Payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1   <= cx_c;
			cy_s1   <= cy_c;
			magx_s1 <= magx_c;
			magy_s1 <= magy_c;

			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			sqx_s2  <= SQ_W'(magx_s1 * magx_s1);
			sqy_s2  <= SQ_W'(magy_s1 * magy_s1);

			m2_s3          <= m2_c;
			num_x_s3       <= numx_c;
			num_y_s3       <= numy_c;
			// inner test wins over the outer one
			side_s3.proj   <= !below_c && above_c;
			side_s3.neg_x  <= cx_s2[CEN_W-1];
			side_s3.neg_y  <= cy_s2[CEN_W-1];
			side_s3.pass_x <= below_c ? '0 : OUT_W'(cx_s2);
			side_s3.pass_y <= below_c ? '0 : OUT_W'(cy_s2);
		end
	end

endmodule

[hdl/rdz_div.sv]
// Restoring divider pipeline: one quotient bit per stage, both axes side by side.
// Divides FS^2*mag^2 by m2. Depends on rdz_pkg.
module rdz_div import rdz_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             v_in,
	input  logic [M2_W-1:0]  m2_in,
	input  logic [NUM_W-1:0] num_x_in,
	input  logic [NUM_W-1:0] num_y_in,
	input  side_t            side_in,
	output logic             v_out,
	output logic [Q_W-1:0]   quo_x,
	output logic [Q_W-1:0]   quo_y,
	output side_t            side_out
);

	logic            v_s    [Q_W];
	logic [M2_W-1:0] d_s    [Q_W];
	logic [M2_W-1:0] rx_s   [Q_W];
	logic [M2_W-1:0] ry_s   [Q_W];
	logic [Q_W-1:0]  wx_s   [Q_W];
	logic [Q_W-1:0]  wy_s   [Q_W];
	side_t           side_s [Q_W];

	// The dividend word shifts out at the top while quotient bits shift in below
	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic            vi;
		logic [M2_W-1:0] di, rxi, ryi;
		logic [Q_W-1:0]  wxi, wyi;
		side_t           si;
		logic [M2_W:0]   tx, ty, nx, ny;
		logic            gx, gy;

		if (k == 0) begin : g_first
			assign vi  = v_in;
			assign di  = m2_in;
			assign rxi = num_x_in[NUM_W-1:Q_W];
			assign ryi = num_y_in[NUM_W-1:Q_W];
			assign wxi = num_x_in[Q_W-1:0];
			assign wyi = num_y_in[Q_W-1:0];
			assign si  = side_in;
		end else begin : g_next
			assign vi  = v_s[k-1];
			assign di  = d_s[k-1];
			assign rxi = rx_s[k-1];
			assign ryi = ry_s[k-1];
			assign wxi = wx_s[k-1];
			assign wyi = wy_s[k-1];
			assign si  = side_s[k-1];
		end

		// Bring down one dividend bit, subtract the divisor where it fits
		assign tx = {rxi, wxi[Q_W-1]};
		assign ty = {ryi, wyi[Q_W-1]};
		assign gx = (tx >= {1'b0, di});
		assign gy = (ty >= {1'b0, di});
		assign nx = gx ? tx - {1'b0, di} : tx;
		assign ny = gy ? ty - {1'b0, di} : ty;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d_s[k]    <= di;
				rx_s[k]   <= nx[M2_W-1:0];
				ry_s[k]   <= ny[M2_W-1:0];
				wx_s[k]   <= {wxi[Q_W-2:0], gx};
				wy_s[k]   <= {wyi[Q_W-2:0], gy};
				side_s[k] <= si;
			end
		end
	end

	assign v_out    = v_s[Q_W-1];
	assign quo_x    = wx_s[Q_W-1];
	assign quo_y    = wy_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule

[hdl/rdz_sqrt.sv]
// Digit-by-digit square root pipeline, one root bit per stage, both axes.
// Applies the axis sign and selects projected or pass value. Depends on rdz_pkg.
module rdz_sqrt import rdz_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    v_in,
	input  logic [Q_W-1:0]          qx_in,
	input  logic [Q_W-1:0]          qy_in,
	input  side_t                   side_in,
	output logic                    v_out,
	output logic signed [OUT_W-1:0] res_x,
	output logic signed [OUT_W-1:0] res_y
);

	logic              v_s    [ROOT_W];
	logic [SR_W-1:0]   rx_s   [ROOT_W];
	logic [SR_W-1:0]   ry_s   [ROOT_W];
	logic [ROOT_W-1:0] rtx_s  [ROOT_W];
	logic [ROOT_W-1:0] rty_s  [ROOT_W];
	logic [Q_W-1:0]    wx_s   [ROOT_W];
	logic [Q_W-1:0]    wy_s   [ROOT_W];
	side_t             side_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              vi;
		logic [SR_W-1:0]   rxi, ryi;
		logic [ROOT_W-1:0] rtxi, rtyi;
		logic [Q_W-1:0]    wxi, wyi;
		side_t             si;
		logic [SR_W+1:0]   tx, ty, trx, try_c, nx, ny;
		logic              gx, gy;

		if (k == 0) begin : g_first
			assign vi   = v_in;
			assign rxi  = '0;
			assign ryi  = '0;
			assign rtxi = '0;
			assign rtyi = '0;
			assign wxi  = qx_in;
			assign wyi  = qy_in;
			assign si   = side_in;
		end else begin : g_next
			assign vi   = v_s[k-1];
			assign rxi  = rx_s[k-1];
			assign ryi  = ry_s[k-1];
			assign rtxi = rtx_s[k-1];
			assign rtyi = rty_s[k-1];
			assign wxi  = wx_s[k-1];
			assign wyi  = wy_s[k-1];
			assign si   = side_s[k-1];
		end

		// Bring down two radicand bits, try the root with a one appended
		assign tx    = {rxi, wxi[Q_W-1:Q_W-2]};
		assign ty    = {ryi, wyi[Q_W-1:Q_W-2]};
		assign trx   = {1'b0, rtxi, 2'b01};
		assign try_c = {1'b0, rtyi, 2'b01};
		assign gx    = (tx >= trx);
		assign gy    = (ty >= try_c);
		assign nx    = gx ? tx - trx : tx;
		assign ny    = gy ? ty - try_c : ty;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rx_s[k]   <= nx[SR_W-1:0];
				ry_s[k]   <= ny[SR_W-1:0];
				rtx_s[k]  <= {rtxi[ROOT_W-2:0], gx};
				rty_s[k]  <= {rtyi[ROOT_W-2:0], gy};
				wx_s[k]   <= {wxi[Q_W-3:0], 2'b00};
				wy_s[k]   <= {wyi[Q_W-3:0], 2'b00};
				side_s[k] <= si;
			end
		end
	end

	// Apply sign to the root, or take the pass value
	logic [OUT_W-1:0] magx, magy;
	side_t            sl;

	assign sl    = side_s[ROOT_W-1];
	assign magx  = OUT_W'(rtx_s[ROOT_W-1]);
	assign magy  = OUT_W'(rty_s[ROOT_W-1]);
	assign v_out = v_s[ROOT_W-1];
	assign res_x = !sl.proj ? sl.pass_x : (sl.neg_x ? -magx : magx);
	assign res_y = !sl.proj ? sl.pass_y : (sl.neg_y ? -magy : magy);

endmodule

[hdl/rdz_obuf.sv]
// Two-entry output buffer that decouples the pipeline from the output handshake.
// Produces the pipeline advance. Depends on rdz_pkg.
module rdz_obuf import rdz_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    v_last,
	input  logic signed [OUT_W-1:0] dx,
	input  logic signed [OUT_W-1:0] dy,
	output logic                    adv,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] out_x,
	output logic signed [OUT_W-1:0] out_y
);

	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [OUT_W-1:0] ex_q [OBUF_DEPTH];
	logic [OUT_W-1:0] ey_q [OBUF_DEPTH];
	logic             full, push, pop;

	// Stall the pipeline only when a result would leave into a full buffer
	assign full      = (count_q == CNT_W'(OBUF_DEPTH));
	assign adv       = !(full && v_last);
	assign push      = adv && v_last;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_x     = ex_q[rd_q];
	assign out_y     = ey_q[rd_q];

	// Track occupancy and pointers; depth is a power of two so pointers wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the beat leaving the pipeline
	always_ff @(posedge clk) begin
		if (push) begin
			ex_q[wr_q] <= dx;
			ey_q[wr_q] <= dy;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("result pushed into a full output buffer");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> full)
		else $error("full output buffer lost a beat without a pop");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("output buffer count wrong after pop");

endmodule

[hdl/stick_radial_deadzone_unit.sv]
// Top level of the stick radial deadzone conditioner.
// Instantiates rdz_front, rdz_div, rdz_sqrt and rdz_obuf; depends on rdz_pkg.
//
//   channel  signals                       accepted when
//   input    in_valid/in_ready, raw_x/y    in_valid && in_ready
//   output   out_valid/out_ready, out_x/y  out_valid && out_ready
//   config   cfg_we, cfg_idx, cfg_wdata    cfg_we (no wait, no read-back)
//
// One beat enters per cycle unless the pipe is stalled. Each result passes
// through the front stages, the one-bit-per-stage divider and square root,
// and then the output buffer.
// Reset clears all valid bits and sets the radii to 0 and 4095.
// A full two-entry output buffer with a result at the pipe end stalls the
// whole pipe; otherwise input is taken while results wait at the output.
module stick_radial_deadzone_unit import rdz_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_BITS-1:0]  raw_x,
	input  logic [SAMPLE_BITS-1:0]  raw_y,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] out_x,
	output logic signed [OUT_W-1:0] out_y,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

	logic                    adv;
	logic                    f_v, d_v, s_v;
	logic [M2_W-1:0]         f_m2;
	logic [NUM_W-1:0]        f_numx, f_numy;
	side_t                   f_side, d_side;
	logic [Q_W-1:0]          d_qx, d_qy;
	logic signed [OUT_W-1:0] s_x, s_y;

	assign in_ready = adv;

	rdz_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.raw_x     (raw_x),
		.raw_y     (raw_y),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.v_s3      (f_v),
		.m2_s3     (f_m2),
		.num_x_s3  (f_numx),
		.num_y_s3  (f_numy),
		.side_s3   (f_side)
	);

	rdz_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_in     (f_v),
		.m2_in    (f_m2),
		.num_x_in (f_numx),
		.num_y_in (f_numy),
		.side_in  (f_side),
		.v_out    (d_v),
		.quo_x    (d_qx),
		.quo_y    (d_qy),
		.side_out (d_side)
	);

	rdz_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_in    (d_v),
		.qx_in   (d_qx),
		.qy_in   (d_qy),
		.side_in (d_side),
		.v_out   (s_v),
		.res_x   (s_x),
		.res_y   (s_y)
	);

	rdz_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_last    (s_v),
		.dx        (s_x),
		.dy        (s_y),
		.adv       (adv),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_x     (out_x),
		.out_y     (out_y)
	);

endmodule
